// ===== sv/fbb_pkg.sv =====
// shared constants and types of the framebuffer blitter
package fbb_pkg;

	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_MAX_HEIGHT = 64;
	localparam int DEF_PIXEL_BITS = 32;

	localparam int CMD_W   = 2;
	localparam int COORD_W = 12;
	localparam int CFG_W   = 7;
	localparam int VALUE_W = 32;
	localparam int REG_W   = 2;

	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUT  = 2'd0,
		CMD_FILL = 2'd1,
		CMD_COPY = 2'd2,
		CMD_READ = 2'd3
	} cmd_t;

	localparam logic [REG_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [REG_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [REG_W-1:0] REG_ROW_PITCH    = 2'd2;

	localparam logic ST_DONE    = 1'b0;
	localparam logic ST_BAD_SRC = 1'b1;

endpackage

// ===== sv/fbb_ram.sv =====
// generic single-clock ram, one write port, one registered read port
module fbb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/framebuffer_blitter_top.sv =====
// framebuffer blitter: pixel frame store with put, fill, copy and read commands
//
//  channel   signals                                   handshake
//  command   start busy cmd pos_x pos_y rect_width     start & !busy
//            rect_height dest_x dest_y color
//  result    done status pixel_value                   done, one cycle, no stall
//  config    cfg_valid cfg_ready cfg_index cfg_data    cfg_valid & cfg_ready
//
//  after reset a clearing pass zeroes the frame store
//  fill walks the clipped area; copy stages it, then writes it at the destination
//  one pixel per cycle, set by the single write port of the frame store
//  one item at a time; busy stays high until the done cycle
//  cfg_ready is always high; the receiver of results cannot stall
module framebuffer_blitter_top
	import fbb_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [CMD_W-1:0]   cmd,
	input  logic [COORD_W-1:0] pos_x,
	input  logic [COORD_W-1:0] pos_y,
	input  logic [COORD_W-1:0] rect_width,
	input  logic [COORD_W-1:0] rect_height,
	input  logic [COORD_W-1:0] dest_x,
	input  logic [COORD_W-1:0] dest_y,
	input  logic [VALUE_W-1:0] color,
	output logic               done,
	output logic               status,
	output logic [VALUE_W-1:0] pixel_value,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [REG_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW    = ((AW > 2 * CFG_W) ? AW : 2 * CFG_W) + 1;
	localparam int XW    = COORD_W + 1;

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_SETUP = 4'd2;
	localparam logic [3:0] S_RDW   = 4'd3;
	localparam logic [3:0] S_FILL  = 4'd4;
	localparam logic [3:0] S_STAGE = 4'd5;
	localparam logic [3:0] S_GAP   = 4'd6;
	localparam logic [3:0] S_WRITE = 4'd7;
	localparam logic [3:0] S_DRAIN = 4'd8;

	logic [3:0]            state_q;
	logic [CFG_W-1:0]      width_q, height_q, pitch_q;
	cmd_t                  cmd_q;
	logic [COORD_W-1:0]    base_x_q, base_y_q, rect_w_q, rect_h_q, dest_x_q, dest_y_q;
	logic [PIXEL_BITS-1:0] color_q;
	logic [CFG_W-1:0]      off_x_q, off_y_q, ext_w_q, ext_h_q;
	logic [AW-1:0]         k_q, clr_q;
	logic                  done_q, status_q;
	logic [PIXEL_BITS-1:0] pixel_q;
	logic                  rd_ok_s1;
	logic                  st_we_s1, st_ok_s1;
	logic [AW-1:0]         st_k_s1;
	logic                  fw_we_s1;
	logic [AW-1:0]         fw_addr_s1;

	logic [CFG_W-1:0]      vis_w, vis_h;
	logic [XW-1:0]         px, py, sum_x, sum_y, xe, ye;
	logic [LW-1:0]         lin;
	logic                  in_frame, pix_ok, src_in_x, src_in_y, walk_last, row_last;
	logic [CFG_W-1:0]      cw, ch;

	logic                  fr_we;
	logic [AW-1:0]         fr_waddr;
	logic [PIXEL_BITS-1:0] fr_wdata, fr_rdata;
	logic                  sg_we;
	logic [PIXEL_BITS-1:0] sg_wdata, sg_rdata;

	// visible frame and pixel address
	assign vis_w = (XW'(width_q) < XW'(MAX_WIDTH)) ? width_q : CFG_W'(MAX_WIDTH);
	assign vis_h = (XW'(height_q) < XW'(MAX_HEIGHT)) ? height_q : CFG_W'(MAX_HEIGHT);

	assign px       = XW'(base_x_q) + XW'(off_x_q);
	assign py       = XW'(base_y_q) + XW'(off_y_q);
	assign in_frame = (px < XW'(vis_w)) && (py < XW'(vis_h));
	assign lin      = LW'(py[CFG_W-1:0]) * LW'(pitch_q) + LW'(px[CFG_W-1:0]);
	assign pix_ok   = in_frame && (lin < LW'(DEPTH));

	// clipped extent
	assign sum_x    = XW'(base_x_q) + XW'(rect_w_q);
	assign sum_y    = XW'(base_y_q) + XW'(rect_h_q);
	assign xe       = (sum_x < XW'(vis_w)) ? sum_x : XW'(vis_w);
	assign ye       = (sum_y < XW'(vis_h)) ? sum_y : XW'(vis_h);
	assign src_in_x = XW'(base_x_q) < XW'(vis_w);
	assign src_in_y = XW'(base_y_q) < XW'(vis_h);
	assign cw       = src_in_x ? CFG_W'(xe - XW'(base_x_q)) : '0;
	assign ch       = src_in_y ? CFG_W'(ye - XW'(base_y_q)) : '0;

	assign row_last  = (off_x_q == ext_w_q - 1'b1);
	assign walk_last = row_last && (off_y_q == ext_h_q - 1'b1);

	// frame store write port
	always_comb begin
		fr_we    = 1'b0;
		fr_waddr = lin[AW-1:0];
		fr_wdata = color_q;
		if (state_q == S_CLEAR) begin
			fr_we    = 1'b1;
			fr_waddr = clr_q;
			fr_wdata = '0;
		end else if (fw_we_s1) begin
			fr_we    = 1'b1;
			fr_waddr = fw_addr_s1;
			fr_wdata = sg_rdata;
		end else if ((state_q == S_SETUP && cmd_q == CMD_PUT) || state_q == S_FILL) begin
			fr_we = pix_ok;
		end
	end

	assign sg_we    = st_we_s1;
	assign sg_wdata = st_ok_s1 ? fr_rdata : '0;

	fbb_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (DEPTH)
	) u_frame (
		.clk   (clk),
		.we    (fr_we),
		.waddr (fr_waddr),
		.wdata (fr_wdata),
		.raddr (lin[AW-1:0]),
		.rdata (fr_rdata)
	);

	fbb_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (DEPTH)
	) u_stage (
		.clk   (clk),
		.we    (sg_we),
		.waddr (st_k_s1),
		.wdata (sg_wdata),
		.raddr (k_q),
		.rdata (sg_rdata)
	);

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_RESET;
			height_q <= CFG_RESET;
			pitch_q  <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
				REG_ROW_PITCH:    pitch_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// command payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cmd_q    <= cmd_t'(cmd);
			rect_w_q <= rect_width;
			rect_h_q <= rect_height;
			dest_x_q <= dest_x;
			dest_y_q <= dest_y;
			color_q  <= color[PIXEL_BITS-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			done_q     <= 1'b0;
			status_q   <= ST_DONE;
			pixel_q    <= '0;
			base_x_q   <= '0;
			base_y_q   <= '0;
			off_x_q    <= '0;
			off_y_q    <= '0;
			ext_w_q    <= '0;
			ext_h_q    <= '0;
			k_q        <= '0;
			rd_ok_s1   <= 1'b0;
			st_we_s1   <= 1'b0;
			st_ok_s1   <= 1'b0;
			st_k_s1    <= '0;
			fw_we_s1   <= 1'b0;
			fw_addr_s1 <= '0;
		end else begin
			done_q   <= 1'b0;
			st_we_s1 <= 1'b0;
			fw_we_s1 <= 1'b0;
			unique case (state_q) inside
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						base_x_q <= pos_x;
						base_y_q <= pos_y;
						off_x_q  <= '0;
						off_y_q  <= '0;
						k_q      <= '0;
						status_q <= ST_DONE;
						pixel_q  <= '0;
						state_q  <= S_SETUP;
					end
				end
				S_SETUP: begin
					ext_w_q <= cw;
					ext_h_q <= ch;
					unique case (cmd_q)
						CMD_PUT: begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
						CMD_READ: begin
							rd_ok_s1 <= pix_ok;
							state_q  <= S_RDW;
						end
						CMD_FILL: begin
							if (cw == '0 || ch == '0) begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								state_q <= S_FILL;
							end
						end
						CMD_COPY: begin
							if (!src_in_x || !src_in_y) begin
								status_q <= ST_BAD_SRC;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else if (cw == '0 || ch == '0) begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								state_q <= S_STAGE;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_RDW: begin
					pixel_q <= rd_ok_s1 ? fr_rdata : '0;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_FILL, S_STAGE, S_WRITE: begin
					if (state_q == S_STAGE) begin
						st_we_s1 <= 1'b1;
						st_ok_s1 <= pix_ok;
						st_k_s1  <= k_q;
					end
					if (state_q == S_WRITE) begin
						fw_we_s1   <= pix_ok;
						fw_addr_s1 <= lin[AW-1:0];
					end
					k_q <= k_q + 1'b1;
					if (row_last) begin
						off_x_q <= '0;
						off_y_q <= off_y_q + 1'b1;
					end else begin
						off_x_q <= off_x_q + 1'b1;
					end
					if (walk_last) begin
						unique case (state_q)
							S_FILL: begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end
							S_STAGE: state_q <= S_GAP;
							default: state_q <= S_DRAIN;
						endcase
					end
				end
				S_GAP: begin
					base_x_q <= dest_x_q;
					base_y_q <= dest_y_q;
					off_x_q  <= '0;
					off_y_q  <= '0;
					k_q      <= '0;
					state_q  <= S_WRITE;
				end
				S_DRAIN: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign pixel_value = VALUE_W'(pixel_q);

	// checks
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not make the block busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without an item at work");

	a_stage_phase: assert property (@(posedge clk) disable iff (!arst_n)
		st_we_s1 |-> (state_q == S_STAGE || state_q == S_GAP))
		else $error("staging write outside the staging phase");

	a_copy_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		fw_we_s1 |-> (state_q == S_WRITE || state_q == S_DRAIN))
		else $error("copy write outside the write phase");

	a_bad_src_copy: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_BAD_SRC |-> cmd_q == CMD_COPY)
		else $error("error status for a command other than copy");

	a_pixel_read_only: assert property (@(posedge clk) disable iff (!arst_n)
		done && pixel_q != '0 |-> cmd_q == CMD_READ)
		else $error("pixel value for a command other than read");

endmodule
